### src/rsi_pkg.sv
// Shared widths, codes and word types for the ray/sphere intersection unit.
// Used by every module under src; no dependencies of its own.
package rsi_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int RADIUS_W  = COORD_W - 1;

  // Intermediate widths, all exact for the extreme inputs
  localparam int D_W    = COORD_W + 1;        // O - C
  localparam int A_W    = 2 * COORD_W;        // |U|^2, unsigned
  localparam int H_W    = 2 * COORD_W + 3;    // (O-C).U and c, signed
  localparam int MUL_W  = H_W + 1;            // wide multiplier operand
  localparam int LIMB_W = MUL_W / 2;
  localparam int PROD_W = 2 * MUL_W;
  localparam int MUL_LAT = 5;
  localparam int DISC_W = 4 * COORD_W + 4;    // non-negative discriminant
  localparam int RAD_W  = DISC_W + 2 * FRAC_BITS;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int NUM_W  = ROOT_W + 3;
  localparam int QB     = COORD_W + 1;        // quotient bits kept before saturation

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = CFG_IDX_W'(3);

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1) << FRAC_BITS;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [QB:0]   NEG_LIMIT = (QB+1)'(1) << (COORD_W - 1);
  localparam logic [QB-1:0] POS_LIMIT = (QB'(1) << (COORD_W - 1)) - QB'(1);

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_MISS     = 2'd1,
    ST_ZERO_DIR = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
  } ray_t;

  typedef struct packed {
    status_t                   status;
    logic signed [COORD_W-1:0] hit_distance;
    logic                      saturated;
  } result_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [RADIUS_W-1:0]       radius;
  } sphere_t;

  // Classified word handed from the front to the back
  typedef struct packed {
    status_t               status;
    logic [DISC_W-1:0]     disc;
    logic signed [H_W-1:0] h;
    logic [A_W-1:0]        a;
  } front_word_t;

endpackage

### src/rsi_wmul.sv
// Pipelined signed multiplier for the discriminant products, built from 4 limb products.
// Depends on rsi_pkg (MUL_W, LIMB_W, PROD_W); one product per cycle.
module rsi_wmul (
  input  logic                               clk,
  input  logic signed [rsi_pkg::MUL_W-1:0]   a_i,
  input  logic signed [rsi_pkg::MUL_W-1:0]   b_i,
  output logic signed [rsi_pkg::PROD_W-1:0]  p_o
);
  import rsi_pkg::*;

  logic [MUL_W-1:0]    ma_r, mb_r;
  logic                sgn1_r, sgn2_r, sgn3_r, sgn4_r;
  logic [2*LIMB_W-1:0] pll_r, plh_r, phl_r, phh_r;
  logic [2*LIMB_W:0]   mid_r;
  logic [PROD_W-1:0]   lohi_r, mag_r;
  logic signed [PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    // take magnitudes
    sgn1_r <= a_i[MUL_W-1] ^ b_i[MUL_W-1];
    ma_r   <= a_i[MUL_W-1] ? MUL_W'(-a_i) : MUL_W'(a_i);
    mb_r   <= b_i[MUL_W-1] ? MUL_W'(-b_i) : MUL_W'(b_i);
    // limb products
    sgn2_r <= sgn1_r;
    pll_r  <= ma_r[LIMB_W-1:0]     * mb_r[LIMB_W-1:0];
    plh_r  <= ma_r[LIMB_W-1:0]     * mb_r[MUL_W-1:LIMB_W];
    phl_r  <= ma_r[MUL_W-1:LIMB_W] * mb_r[LIMB_W-1:0];
    phh_r  <= ma_r[MUL_W-1:LIMB_W] * mb_r[MUL_W-1:LIMB_W];
    // outer limbs do not overlap: concatenate, add the middle terms
    sgn3_r <= sgn2_r;
    mid_r  <= {1'b0, plh_r} + {1'b0, phl_r};
    lohi_r <= {phh_r, pll_r};
    sgn4_r <= sgn3_r;
    mag_r  <= lohi_r + PROD_W'({mid_r, {LIMB_W{1'b0}}});
    // restore sign
    p_r    <= sgn4_r ? $signed(-mag_r) : $signed(mag_r);
  end

  assign p_o = p_r;

endmodule

### src/rsi_front.sv
// Front end: forms a, h, c and the discriminant for each ray and classifies it.
// Depends on rsi_pkg and rsi_wmul; fixed latency, one ray per cycle.
module rsi_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  rsi_pkg::ray_t         in_ray,
  input  rsi_pkg::sphere_t      sphere,
  output logic                  out_valid,
  output rsi_pkg::front_word_t  out_word
);
  import rsi_pkg::*;

  localparam int LAT = 3 + MUL_LAT + 1;

  logic [LAT-1:0]               v_r;
  logic signed [D_W-1:0]        d_r [3];
  logic signed [COORD_W-1:0]    u_r [3];
  logic [RADIUS_W-1:0]          r_r;
  logic signed [A_W-1:0]        uu_r [3];
  logic signed [A_W:0]          du_r [3];
  logic signed [A_W+1:0]        dd_r [3];
  logic [2*RADIUS_W-1:0]        rr_r;
  logic [A_W-1:0]               a_r;
  logic signed [H_W-1:0]        h_r, c_r;
  logic [A_W-1:0]               a_dly_r [MUL_LAT];
  logic signed [H_W-1:0]        h_dly_r [MUL_LAT];
  logic signed [PROD_W-1:0]     hh, ac;
  logic signed [PROD_W:0]       disc;
  front_word_t                  word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    d_r[0] <= D_W'(in_ray.origin_x) - D_W'(sphere.center_x);
    d_r[1] <= D_W'(in_ray.origin_y) - D_W'(sphere.center_y);
    d_r[2] <= D_W'(in_ray.origin_z) - D_W'(sphere.center_z);
    u_r[0] <= in_ray.dir_x;
    u_r[1] <= in_ray.dir_y;
    u_r[2] <= in_ray.dir_z;
    r_r    <= sphere.radius;

    for (int i = 0; i < 3; i++) begin
      uu_r[i] <= u_r[i] * u_r[i];
      du_r[i] <= d_r[i] * u_r[i];
      dd_r[i] <= d_r[i] * d_r[i];
    end
    rr_r <= r_r * r_r;

    a_r <= A_W'(uu_r[0]) + A_W'(uu_r[1]) + A_W'(uu_r[2]);
    h_r <= H_W'(du_r[0]) + H_W'(du_r[1]) + H_W'(du_r[2]);
    c_r <= H_W'(dd_r[0]) + H_W'(dd_r[1]) + H_W'(dd_r[2]) - $signed(H_W'(rr_r));

    // hold a and h beside the multipliers
    a_dly_r[0] <= a_r;
    h_dly_r[0] <= h_r;
    for (int k = 1; k < MUL_LAT; k++) begin
      a_dly_r[k] <= a_dly_r[k-1];
      h_dly_r[k] <= h_dly_r[k-1];
    end

    word_r.status <= (a_dly_r[MUL_LAT-1] == '0) ? ST_ZERO_DIR :
                     disc[PROD_W]               ? ST_MISS     : ST_HIT;
    word_r.disc   <= disc[DISC_W-1:0];
    word_r.h      <= h_dly_r[MUL_LAT-1];
    word_r.a      <= a_dly_r[MUL_LAT-1];
  end

  rsi_wmul u_mul_hh (
    .clk (clk),
    .a_i (MUL_W'(h_r)),
    .b_i (MUL_W'(h_r)),
    .p_o (hh)
  );

  rsi_wmul u_mul_ac (
    .clk (clk),
    .a_i ($signed(MUL_W'(a_r))),
    .b_i (MUL_W'(c_r)),
    .p_o (ac)
  );

  assign disc      = (PROD_W+1)'(hh) - (PROD_W+1)'(ac);
  assign out_valid = v_r[LAT-1];
  assign out_word  = word_r;

endmodule

### src/rsi_queue.sv
// Short queue between front and back; the back drains one word per cycle.
// Depends on rsi_pkg (front_word_t, Q_DEPTH).
module rsi_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  rsi_pkg::front_word_t  din,
  output logic                  out_valid,
  output rsi_pkg::front_word_t  dout,
  output logic                  almost_full
);
  import rsi_pkg::*;

  front_word_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]     count_r;
  logic                 pop;
  front_word_t          dout_r;
  logic                 out_valid_r;

  assign pop = (count_r != '0);

  // registered read: the popped word shows up on dout in the cycle after pop
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
    if (pop) begin
      dout_r <= mem_r[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      out_valid_r <= pop;
      case ({push, pop})
        2'b10:   count_r <= count_r + (Q_PTR_W+1)'(1);
        2'b01:   count_r <= count_r - (Q_PTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign dout        = dout_r;
  assign almost_full = (count_r >= (Q_PTR_W+1)'(Q_DEPTH - 1));

endmodule

### src/rsi_back.sv
// Back end: square root of the scaled discriminant, numerator, floor division by a, saturation.
// Depends on rsi_pkg; one bit per stage in both the root and the quotient pipelines.
module rsi_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  rsi_pkg::front_word_t  in_word,
  output logic                  out_valid,
  output rsi_pkg::result_t      out_result
);
  import rsi_pkg::*;

  typedef struct packed {
    status_t               status;
    logic [RAD_W-1:0]      rad;
    logic [REM_W-1:0]      rem;
    logic [ROOT_W-1:0]     root;
    logic signed [H_W-1:0] h;
    logic [A_W-1:0]        a;
  } sq_t;

  typedef struct packed {
    status_t          status;
    logic             neg;
    logic             ovf;
    logic [QB-1:0]    bits;
    logic [A_W-1:0]   rem;
    logic [QB-1:0]    q;
    logic [A_W-1:0]   a;
  } dv_t;

  function automatic sq_t sq_step(sq_t s);
    sq_t              o;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;
    rem_sh = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
    trial  = {s.root, 2'b01};
    ge     = (rem_sh >= trial);
    o      = s;
    o.rad  = s.rad << 2;
    o.rem  = ge ? rem_sh - trial : rem_sh;
    o.root = {s.root[ROOT_W-2:0], ge};
    return o;
  endfunction

  function automatic dv_t dv_step(dv_t s);
    dv_t            o;
    logic [A_W:0]   rem_sh;
    logic           ge;
    rem_sh = {s.rem, s.bits[QB-1]};
    ge     = (rem_sh >= {1'b0, s.a});
    o      = s;
    o.rem  = ge ? A_W'(rem_sh - {1'b0, s.a}) : rem_sh[A_W-1:0];
    o.q    = {s.q[QB-2:0], ge};
    o.bits = s.bits << 1;
    return o;
  endfunction

  sq_t                    sq_r [ROOT_W+1];
  logic [ROOT_W:0]        sq_v_r;
  logic signed [NUM_W-1:0] num_r;
  status_t                num_st_r, mag_st_r;
  logic [A_W-1:0]         num_a_r, mag_a_r;
  logic                   num_v_r, mag_v_r;
  logic [NUM_W-1:0]       mag_r;
  logic                   neg_r;
  dv_t                    dv_r [QB+1];
  logic [QB:0]            dv_v_r;
  result_t                res_nxt, res_r;
  logic                   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r      <= '0;
      num_v_r     <= 1'b0;
      mag_v_r     <= 1'b0;
      dv_v_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sq_v_r      <= {sq_v_r[ROOT_W-1:0], in_valid};
      num_v_r     <= sq_v_r[ROOT_W];
      mag_v_r     <= num_v_r;
      dv_v_r      <= {dv_v_r[QB-1:0], mag_v_r};
      out_valid_r <= dv_v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    // root of disc * 2^(2*FRAC_BITS), two radicand bits per stage
    sq_r[0].status <= in_word.status;
    sq_r[0].rad    <= {in_word.disc, {(2*FRAC_BITS){1'b0}}};
    sq_r[0].rem    <= '0;
    sq_r[0].root   <= '0;
    sq_r[0].h      <= in_word.h;
    sq_r[0].a      <= in_word.a;
    for (int k = 0; k < ROOT_W; k++) begin
      sq_r[k+1] <= sq_step(sq_r[k]);
    end

    num_r    <= -($signed(NUM_W'(sq_r[ROOT_W].h)) <<< FRAC_BITS)
                - $signed(NUM_W'(sq_r[ROOT_W].root));
    num_st_r <= sq_r[ROOT_W].status;
    num_a_r  <= sq_r[ROOT_W].a;

    neg_r    <= num_r[NUM_W-1];
    mag_r    <= num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
    mag_st_r <= num_st_r;
    mag_a_r  <= num_a_r;

    // a quotient of 2^QB or more always saturates
    dv_r[0].status <= mag_st_r;
    dv_r[0].neg    <= neg_r;
    dv_r[0].ovf    <= ((mag_r >> QB) >= NUM_W'(mag_a_r));
    dv_r[0].bits   <= mag_r[QB-1:0];
    dv_r[0].rem    <= A_W'(mag_r >> QB);
    dv_r[0].q      <= '0;
    dv_r[0].a      <= mag_a_r;
    for (int j = 0; j < QB; j++) begin
      dv_r[j+1] <= dv_step(dv_r[j]);
    end

    res_r <= res_nxt;
  end

  always_comb begin
    dv_t         d;
    logic [QB:0] q_up;
    logic        sat;
    d    = dv_r[QB];
    // round toward minus infinity for a negative numerator
    q_up = {1'b0, d.q} + (QB+1)'(d.rem != '0);
    sat  = 1'b0;
    res_nxt.status       = d.status;
    res_nxt.hit_distance = '0;
    res_nxt.saturated    = 1'b0;
    if (d.status == ST_HIT) begin
      if (d.neg) begin
        sat = d.ovf || (q_up > NEG_LIMIT);
        res_nxt.hit_distance = sat ? COORD_MIN : -q_up[COORD_W-1:0];
      end else begin
        sat = d.ovf || (d.q > POS_LIMIT);
        res_nxt.hit_distance = sat ? COORD_MAX : d.q[COORD_W-1:0];
      end
      res_nxt.saturated = sat;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = res_r;

endmodule

### src/ray_sphere_intersect_unit.sv
// Ray/sphere intersection unit: top level with sphere registers, front, queue and back.
// A taken ray passes the front, the queue and the back (82 root stages, 33 quotient
// stages and glue) before its out_valid strobe.
// Throughput: one ray per cycle while busy is low; busy rises only if the queue runs to one free slot.
// Results cannot be stalled. Synchronous active-low reset clears all valids and loads
// center (0,0,0) and radius 1.0.
module ray_sphere_intersect_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  rsi_pkg::ray_t                    in_ray,
  output logic                             out_valid,
  output rsi_pkg::result_t                 out_result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rsi_pkg::COORD_W-1:0]      cfg_data
);
  import rsi_pkg::*;

  sphere_t      sphere_r;
  logic         accept;
  logic         front_valid;
  front_word_t  front_word;
  logic         q_valid;
  front_word_t  q_word;
  logic         q_almost_full;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = q_almost_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sphere_r.center_x <= '0;
      sphere_r.center_y <= '0;
      sphere_r.center_z <= '0;
      sphere_r.radius   <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CENTER_X: sphere_r.center_x <= $signed(cfg_data);
        REG_CENTER_Y: sphere_r.center_y <= $signed(cfg_data);
        REG_CENTER_Z: sphere_r.center_z <= $signed(cfg_data);
        REG_RADIUS:   sphere_r.radius   <= cfg_data[RADIUS_W-1:0];
        default:      ; // drop writes to unused indexes
      endcase
    end
  end

  rsi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_ray    (in_ray),
    .sphere    (sphere_r),
    .out_valid (front_valid),
    .out_word  (front_word)
  );

  rsi_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (front_valid),
    .din         (front_word),
    .out_valid   (q_valid),
    .dout        (q_word),
    .almost_full (q_almost_full)
  );

  rsi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (q_valid),
    .in_word    (q_word),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule
